// ===== rtl/assert_macros.svh =====
// Assertion macros used by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_INV(lbl, clk, rst_n, cond) \
  `ASSERT_CLK(lbl, clk, rst_n, (cond))

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_INV(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/b64sd_pkg.sv =====
`timescale 1ns / 1ps

package b64sd_pkg;

  localparam int unsigned MarkerLen = 7;

  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  function automatic logic [7:0] marker_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h62;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h73;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h36;
      3'd5:    c = 8'h34;
      3'd6:    c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    priority if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == CharPlus) begin
      s.value = 6'd62;
    end else if (c == CharSlash) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

  function automatic logic is_skipped(input logic [7:0] c);
    return (c == CharEq) || (c == CharSpace) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

// ===== rtl/base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// Streaming base64 decoder, one character per input beat.
// The input channel carries in_char_i and in_last_i under in_valid_i and in_ready_o.
// Every input beat produces exactly one output beat on the output channel, with
// out_byte_o and byte_valid_o for a completed byte, restart_o when the first
// "base64," marker of the string completes, and done_res_o and invalid_o on the
// beat of the last character. Padding and whitespace produce a beat with no byte.
// The decode state is updated in the cycle a beat is accepted and the result is
// held in one output register, so out_valid_o rises in the cycle after
// acceptance. One beat can be accepted in every cycle unless the receiver stalls;
// throughput is one character per cycle, set by the single output register.
// While the receiver stalls with a result held, in_ready_o is low; it follows
// out_ready_i combinationally so a full register is refilled as it drains.
// Reset clears the accumulator, bit count, marker match and error flag and
// empties the output register. The same state returns to reset values after the
// last character of each string, so the next beat starts a new string.

`include "assert_macros.svh"

module base64_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       restart_o,
  output logic       done_res_o,
  output logic       invalid_o
);

  logic [11:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  prog_q, prog_d;
  logic        seen_q, seen_d;
  logic        err_q, err_d;

  logic        out_valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        bvalid_q, bvalid_d;
  logic        restart_q, restart_d;
  logic        done_q;
  logic        invalid_q, invalid_d;

  logic               in_fire;
  b64sd_pkg::sextet_t sx;
  logic [11:0]        acc_shift;
  logic [3:0]         cnt_sum;
  logic [3:0]         cnt_left;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign sx        = b64sd_pkg::sextet_of(in_char_i);
  assign acc_shift = {acc_q[5:0], sx.value};
  assign cnt_sum   = {1'b0, cnt_q} + 4'd6;
  assign cnt_left  = cnt_sum - 4'd8;

  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    prog_d    = prog_q;
    seen_d    = seen_q;
    err_d     = err_q;
    byte_d    = 8'd0;
    bvalid_d  = 1'b0;
    restart_d = 1'b0;

    if (!seen_q) begin
      if (in_char_i == b64sd_pkg::marker_char(prog_q)) begin
        if (prog_q == 3'(b64sd_pkg::MarkerLen - 1)) begin
          restart_d = 1'b1;
          seen_d    = 1'b1;
          prog_d    = 3'd0;
        end else begin
          prog_d = prog_q + 3'd1;
        end
      end else begin
        prog_d = (in_char_i == b64sd_pkg::marker_char(3'd0)) ? 3'd1 : 3'd0;
      end
    end

    if (restart_d) begin
      acc_d = 12'd0;
      cnt_d = 3'd0;
      err_d = 1'b0;
    end else if (!b64sd_pkg::is_skipped(in_char_i)) begin
      if (!sx.valid) begin
        err_d = 1'b1;
      end else if (!err_q) begin
        acc_d = acc_shift;
        if (cnt_sum >= 4'd8) begin
          cnt_d    = cnt_left[2:0];
          bvalid_d = 1'b1;
          unique case (cnt_left[2:1])
            2'd0:    byte_d = acc_shift[7:0];
            2'd1:    byte_d = acc_shift[9:2];
            default: byte_d = acc_shift[11:4];
          endcase
        end else begin
          cnt_d = cnt_sum[2:0];
        end
      end
    end

    invalid_d = in_last_i && err_d;

    if (in_last_i) begin
      acc_d  = 12'd0;
      cnt_d  = 3'd0;
      prog_d = 3'd0;
      seen_d = 1'b0;
      err_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= 12'd0;
      cnt_q       <= 3'd0;
      prog_q      <= 3'd0;
      seen_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        acc_q  <= acc_d;
        cnt_q  <= cnt_d;
        prog_q <= prog_d;
        seen_q <= seen_d;
        err_q  <= err_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q    <= byte_d;
      bvalid_q  <= bvalid_d;
      restart_q <= restart_d;
      done_q    <= in_last_i;
      invalid_q <= invalid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bvalid_q;
  assign restart_o    = restart_q;
  assign done_res_o   = done_q;
  assign invalid_o    = invalid_q;

  `ASSERT_CLK(a_fire_gives_result, clk_i, rst_ni, in_fire |=> out_valid_q)
  `ASSERT_CLK(a_last_clears_state, clk_i, rst_ni,
              in_fire && in_last_i |=> !seen_q && !err_q && cnt_q == 3'd0)
  `ASSERT_INV(a_count_even, clk_i, rst_ni, cnt_q[0] == 1'b0)
  `ASSERT_INV(a_restart_no_byte, clk_i, rst_ni,
              !(out_valid_q && restart_q && bvalid_q))
  `ASSERT_INV(a_progress_range, clk_i, rst_ni, prog_q != 3'd7)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       restart;
    logic       done;
    logic       invalid;
  } decode_result_t;

  typedef logic [7:0] text_t[$];

  localparam logic [8*b64sd_pkg::MarkerLen-1:0] MarkerBits = "base64,";
  localparam int unsigned WellformedItems = 1000;
  localparam int unsigned RandomItems = 1450;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_char = 8'h00;
  logic in_last = 1'b0;
  logic out_ready = 1'b0;

  logic in_ready_o;
  logic out_valid_o;
  logic [7:0] out_byte_o;
  logic byte_valid_o;
  logic restart_o;
  logic done_res_o;
  logic invalid_o;

  logic [11:0] acc_bits;
  int unsigned acc_count;
  int unsigned marker_pos;
  logic marker_found;
  logic decode_error;

  decode_result_t decode_results_q[$];
  int unsigned mismatch_count;
  int unsigned chars_sent;
  bit tx_burst;
  bit rx_burst;

  base64_stream_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .in_char_i    (in_char),
    .in_last_i    (in_last),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .restart_o    (restart_o),
    .done_res_o   (done_res_o),
    .invalid_o    (invalid_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] marker_at(input int unsigned pos);
    return MarkerBits[8*(b64sd_pkg::MarkerLen-1-pos) +: 8];
  endfunction

  function automatic void clear_decoder();
    acc_bits = '0;
    acc_count = 0;
    marker_pos = 0;
    marker_found = 1'b0;
    decode_error = 1'b0;
  endfunction

  function automatic decode_result_t decode_char(input logic [7:0] c, input logic last);
    decode_result_t r;
    int unsigned pos;
    logic [5:0] sextet;
    logic in_alphabet;
    r = '0;
    if (!marker_found) begin
      pos = marker_pos;
      if (pos < b64sd_pkg::MarkerLen && c == marker_at(pos)) begin
        pos++;
      end else begin
        pos = (c == marker_at(0)) ? 1 : 0;
      end
      if (pos >= b64sd_pkg::MarkerLen) begin
        r.restart = 1'b1;
        marker_found = 1'b1;
        marker_pos = 0;
      end else begin
        marker_pos = pos;
      end
    end
    in_alphabet = 1'b1;
    sextet = '0;
    if (c >= "A" && c <= "Z") begin
      sextet = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      sextet = 6'(c - "a" + 26);
    end else if (c >= "0" && c <= "9") begin
      sextet = 6'(c - "0" + 52);
    end else if (c == b64sd_pkg::CharPlus) begin
      sextet = 6'd62;
    end else if (c == b64sd_pkg::CharSlash) begin
      sextet = 6'd63;
    end else begin
      in_alphabet = 1'b0;
    end
    if (r.restart) begin
      acc_bits = '0;
      acc_count = 0;
      decode_error = 1'b0;
    end else if (!(c == b64sd_pkg::CharEq || c == b64sd_pkg::CharSpace ||
                   (c >= 8'd9 && c <= 8'd13))) begin
      if (!in_alphabet) begin
        decode_error = 1'b1;
      end else if (!decode_error) begin
        acc_bits = {acc_bits[5:0], sextet};
        acc_count += 6;
        if (acc_count >= 8) begin
          acc_count -= 8;
          r.data = 8'(acc_bits >> acc_count);
          r.has_byte = 1'b1;
        end
      end
    end
    r.done = last;
    r.invalid = last && decode_error;
    if (last) begin
      clear_decoder();
    end
    return r;
  endfunction

  function automatic logic [7:0] random_b64_char();
    int unsigned v;
    v = $urandom_range(0, 63);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? b64sd_pkg::CharPlus : b64sd_pkg::CharSlash;
  endfunction

  function automatic logic [7:0] random_skip_char();
    int unsigned v;
    v = $urandom_range(0, 6);
    if (v == 5) return b64sd_pkg::CharSpace;
    if (v == 6) return b64sd_pkg::CharEq;
    return 8'(9 + v);
  endfunction

  function automatic void append_text(ref text_t t, input string s);
    for (int i = 0; i < s.len(); i++) begin
      t.insert(t.size(), s[i]);
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_char <= c;
    in_last <= last;
    do @(posedge clk_i); while (!in_ready_o);
    decode_results_q.insert(decode_results_q.size(), decode_char(c, last));
    chars_sent++;
  endtask

  task automatic send_text(input text_t t);
    foreach (t[i]) begin
      send_char(t[i], i == t.size() - 1);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (decode_results_q.size() != 0);
  endtask

  task automatic randomize_idling();
    tx_burst = ($urandom_range(0, 5) == 0);
    rx_burst = ($urandom_range(0, 5) == 0);
  endtask

  task automatic test_directed_marker();
    text_t t;
    t.insert(t.size(), 8'hFF);
    append_text(t, "base64,/+AZaz09,");
    send_text(t);
  endtask

  task automatic test_directed_skips();
    text_t t;
    for (int c = 9; c <= 13; c++) begin
      t.insert(t.size(), 8'(c));
    end
    t.insert(t.size(), b64sd_pkg::CharSpace);
    t.insert(t.size(), b64sd_pkg::CharEq);
    t.insert(t.size(), 8'h00);
    send_text(t);
  endtask

  task automatic send_wellformed_string();
    text_t t;
    int unsigned body_len;
    int unsigned v;
    case ($urandom_range(0, 3))
      0: append_text(t, "data:image/png;");
      1: repeat ($urandom_range(1, 6)) t.insert(t.size(), random_b64_char());
      2: append_text(t, "bas");
      default: ;
    endcase
    append_text(t, "base64,");
    body_len = ($urandom_range(0, 15) == 0) ? 40 : $urandom_range(0, 12);
    repeat (body_len) begin
      v = $urandom_range(0, 31);
      if (v < 2) begin
        t.insert(t.size(), random_skip_char());
      end else if (v == 2) begin
        t.insert(t.size(), 8'($urandom_range(0, 255)));
      end else if (v == 3) begin
        append_text(t, "base64,");
      end else begin
        t.insert(t.size(), random_b64_char());
      end
    end
    send_text(t);
  endtask

  task automatic send_noise_string();
    text_t t;
    int unsigned v;
    repeat ($urandom_range(1, 20)) begin
      v = $urandom_range(0, 7);
      if (v < 3) begin
        t.insert(t.size(), 8'($urandom_range(0, 255)));
      end else if (v == 3) begin
        append_text(t, "base6");
      end else if (v == 4) begin
        t.insert(t.size(), marker_at($urandom_range(0, b64sd_pkg::MarkerLen - 1)));
      end else if (v == 5) begin
        t.insert(t.size(), random_skip_char());
      end else begin
        t.insert(t.size(), random_b64_char());
      end
    end
    send_text(t);
  endtask

  task automatic test_wellformed_strings();
    while (chars_sent < WellformedItems) begin
      randomize_idling();
      send_wellformed_string();
    end
  endtask

  task automatic test_drain_pause();
    repeat (6) begin
      randomize_idling();
      send_wellformed_string();
      wait_for_results();
    end
  endtask

  task automatic test_noise_strings();
    while (chars_sent < RandomItems) begin
      randomize_idling();
      if ($urandom_range(0, 2) == 0) begin
        send_wellformed_string();
      end else begin
        send_noise_string();
      end
    end
  endtask

  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    decode_result_t seen;
    decode_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      seen = '{out_byte_o, byte_valid_o, restart_o, done_res_o, invalid_o};
      if (decode_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected beat: data=%02h byte=%0b restart=%0b done=%0b invalid=%0b",
                   seen.data, seen.has_byte, seen.restart, seen.done, seen.invalid);
        end
      end else begin
        want = decode_results_q.pop_front();
        if (seen.data !== want.data || seen.has_byte !== want.has_byte ||
            seen.restart !== want.restart || seen.done !== want.done ||
            seen.invalid !== want.invalid) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected data=%02h byte=%0b restart=%0b done=%0b invalid=%0b",
                     want.data, want.has_byte, want.restart, want.done, want.invalid);
            $display("          actual   data=%02h byte=%0b restart=%0b done=%0b invalid=%0b",
                     seen.data, seen.has_byte, seen.restart, seen.done, seen.invalid);
          end
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    clear_decoder();
    mismatch_count = 0;
    chars_sent = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_marker();
    test_directed_skips();
    test_wellformed_strings();
    test_drain_pause();
    test_noise_strings();
    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && decode_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
